// ----- rtl/polsu_pkg.sv -----
// Shared types, codes and widths for the positional ordered list store.
package polsu_pkg;

    localparam int OP_W        = 3;
    localparam int VALUE_W     = 32;
    localparam int POS_W       = 5;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 5;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_BACK  = 3'd4,
        OP_DEL_AT    = 3'd5,
        OP_LIST      = 3'd6
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_BADPOS = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_INSERT,
        KIND_DELETE,
        KIND_LIST
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_INS_STEP,
        S_INS_WR,
        S_DEL_STEP,
        S_DEL_WR,
        S_LIST_RD,
        S_LIST_OUT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic load_req;
        logic load_status;
        logic idx_count;
        logic idx_target;
        logic idx_zero;
        logic idx_inc;
        logic idx_dec;
        logic rd_prev;
        logic rd_next;
        logic rd_cur;
        logic wr_value;
        logic wr_data;
        logic cnt_inc;
        logic cnt_dec;
        logic emit_one;
        logic emit_list;
    } dp_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  fail;
        logic  list_empty;
        logic  at_target;
        logic  at_last;
        logic  out_free;
    } dp_stat_t;

endpackage

// ----- rtl/polsu_ctrl.sv -----
// Controller state machine: sequences request decode, entry walks and result emission.
module polsu_ctrl
    import polsu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.kind == KIND_NONE || stat.fail)
                begin
                    state_next = S_EMIT;
                end
                else if (stat.kind == KIND_LIST)
                begin
                    state_next = stat.list_empty ? S_EMIT : S_LIST_RD;
                end
                else if (stat.kind == KIND_INSERT)
                begin
                    state_next = S_INS_STEP;
                end
                else
                begin
                    state_next = S_DEL_STEP;
                end
            end
            S_INS_STEP:
            begin
                state_next = stat.at_target ? S_EMIT : S_INS_WR;
            end
            S_INS_WR:
            begin
                state_next = S_INS_STEP;
            end
            S_DEL_STEP:
            begin
                state_next = stat.at_last ? S_EMIT : S_DEL_WR;
            end
            S_DEL_WR:
            begin
                state_next = S_DEL_STEP;
            end
            S_LIST_RD:
            begin
                state_next = S_LIST_OUT;
            end
            S_LIST_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.at_last ? S_IDLE : S_LIST_RD;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready    = 1'b1;
                cmd.load_req = req_valid;
            end
            S_CHECK:
            begin
                cmd.load_status = 1'b1;
                if (!stat.fail)
                begin
                    cmd.idx_count  = (stat.kind == KIND_INSERT);
                    cmd.idx_target = (stat.kind == KIND_DELETE);
                    cmd.idx_zero   = (stat.kind == KIND_LIST);
                end
            end
            S_INS_STEP:
            begin
                if (stat.at_target)
                begin
                    cmd.wr_value = 1'b1;
                    cmd.cnt_inc  = 1'b1;
                end
                else
                begin
                    cmd.rd_prev = 1'b1;
                end
            end
            S_INS_WR:
            begin
                cmd.wr_data = 1'b1;
                cmd.idx_dec = 1'b1;
            end
            S_DEL_STEP:
            begin
                if (stat.at_last)
                begin
                    cmd.cnt_dec = 1'b1;
                end
                else
                begin
                    cmd.rd_next = 1'b1;
                end
            end
            S_DEL_WR:
            begin
                cmd.wr_data = 1'b1;
                cmd.idx_inc = 1'b1;
            end
            S_LIST_RD:
            begin
                cmd.rd_cur = 1'b1;
            end
            S_LIST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_list = 1'b1;
                    cmd.idx_inc   = !stat.at_last;
                end
            end
            S_EMIT:
            begin
                cmd.emit_one = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/polsu_dp.sv -----
// Datapath: request registers, entry memory, walk index, count and result register.
module polsu_dp
    import polsu_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [OP_W-1:0]     req_op,
    input  logic [VALUE_W-1:0]  req_value,
    input  logic [POS_W-1:0]    req_pos,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    input  logic                res_ready,
    output logic                res_valid,
    output logic [STATUS_W-1:0] res_status,
    output logic [VALUE_W-1:0]  res_value,
    output logic [COUNT_W-1:0]  res_count,
    output logic                res_last
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic [DATA_WIDTH-1:0] mem [CAPACITY];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic [OP_W-1:0]    op_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [POS_W-1:0]   pos_reg;
    status_t            status_reg;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] idx_next;

    logic                res_valid_reg;
    logic                res_valid_next;
    logic [STATUS_W-1:0] res_status_reg;
    logic [VALUE_W-1:0]  res_value_reg;
    logic [COUNT_W-1:0]  res_count_reg;
    logic                res_last_reg;

    logic [CMPW-1:0]       pos_c;
    logic [CMPW-1:0]       cnt_c;
    logic                  full;
    logic                  empty;
    status_t               chk_status;
    kind_t                 kind;
    logic [AW-1:0]         tgt_idx;
    logic [AW-1:0]         rd_addr;
    logic                  mem_re;
    logic                  mem_we;
    logic [DATA_WIDTH-1:0] wr_word;
    logic                  out_free;

    assign pos_c    = CMPW'(pos_reg);
    assign cnt_c    = CMPW'(count_reg);
    assign full     = (cnt_c == CMPW'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign out_free = !res_valid_reg || res_ready;

    // Decode the held request against the current count
    always_comb
    begin
        kind       = KIND_NONE;
        chk_status = STAT_OK;
        tgt_idx    = '0;
        case (op_reg)
            OP_INS_FRONT, OP_INS_BACK:
            begin
                kind       = KIND_INSERT;
                chk_status = full ? STAT_FULL : STAT_OK;
                tgt_idx    = (op_reg == OP_INS_FRONT) ? '0 : AW'(count_reg);
            end
            OP_INS_AT:
            begin
                kind = KIND_INSERT;
                if (pos_c == '0 || pos_c > cnt_c + CMPW'(1))
                begin
                    chk_status = STAT_BADPOS;
                end
                else if (full)
                begin
                    chk_status = STAT_FULL;
                end
                tgt_idx = AW'(pos_c - CMPW'(1));
            end
            OP_DEL_FRONT, OP_DEL_BACK:
            begin
                kind       = KIND_DELETE;
                chk_status = empty ? STAT_EMPTY : STAT_OK;
                tgt_idx    = (op_reg == OP_DEL_FRONT) ? '0 : AW'(cnt_c - CMPW'(1));
            end
            OP_DEL_AT:
            begin
                kind = KIND_DELETE;
                if (pos_c == '0 || pos_c > cnt_c)
                begin
                    chk_status = STAT_BADPOS;
                end
                tgt_idx = AW'(pos_c - CMPW'(1));
            end
            OP_LIST:
            begin
                kind       = KIND_LIST;
                chk_status = empty ? STAT_EMPTY : STAT_OK;
            end
            default:
            begin
                kind = KIND_NONE;
            end
        endcase
    end

    assign stat.kind       = kind;
    assign stat.fail       = (kind != KIND_LIST) && (chk_status != STAT_OK);
    assign stat.list_empty = empty;
    assign stat.at_target  = (idx_reg == tgt_idx);
    assign stat.at_last    = ((CMPW'(idx_reg) + CMPW'(1)) == cnt_c);
    assign stat.out_free   = out_free;

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            op_reg    <= req_op;
            value_reg <= req_value;
            pos_reg   <= req_pos;
        end
        if (cmd.load_status)
        begin
            status_reg <= chk_status;
        end
    end

    // Walk index
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_count)
        begin
            idx_next = AW'(count_reg);
        end
        else if (cmd.idx_target)
        begin
            idx_next = tgt_idx;
        end
        else if (cmd.idx_zero)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + AW'(1);
        end
        else if (cmd.idx_dec)
        begin
            idx_next = idx_reg - AW'(1);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Single-port style entry store: one write and one registered read per cycle
    always_comb
    begin
        rd_addr = idx_reg;
        if (cmd.rd_prev)
        begin
            rd_addr = idx_reg - AW'(1);
        end
        else if (cmd.rd_next)
        begin
            rd_addr = idx_reg + AW'(1);
        end
    end

    assign mem_re  = cmd.rd_prev || cmd.rd_next || cmd.rd_cur;
    assign mem_we  = cmd.wr_value || cmd.wr_data;
    assign wr_word = cmd.wr_value ? DATA_WIDTH'(value_reg) : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[idx_reg] <= wr_word;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Result register: hold until taken
    always_comb
    begin
        res_valid_next = res_valid_reg && !res_ready;
        if (cmd.emit_one || cmd.emit_list)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_one)
        begin
            res_status_reg <= status_reg;
            res_value_reg  <= '0;
            res_count_reg  <= COUNT_W'(count_reg);
            res_last_reg   <= 1'b1;
        end
        else if (cmd.emit_list)
        begin
            res_status_reg <= STAT_OK;
            res_value_reg  <= VALUE_W'(rd_data_reg);
            res_count_reg  <= COUNT_W'(count_reg);
            res_last_reg   <= stat.at_last;
        end
    end

    assign res_valid  = res_valid_reg;
    assign res_status = res_status_reg;
    assign res_value  = res_value_reg;
    assign res_count  = res_count_reg;
    assign res_last   = res_last_reg;

endmodule

// ----- rtl/positional_ordered_list_store_unit.sv -----
// Top level of the positional ordered list store: stream ports, controller and datapath.
//
//  channel   | direction | tdata fields (low bit up)                      | tlast
//  s_axis    | in        | operation[2:0] value[34:3] position[39:35]     | -
//  m_axis    | out       | status[1:0] item_value[33:2] item_count[38:34] | last_item
//
// One request is in flight at a time; s_axis_tready is high only while idle.
// Insert or delete: the walk reads each moved entry and writes it into its neighbouring slot.
// List: one memory read per result.
// Reset empties the list; entry contents are not cleared.
// A stalled m_axis holds the result register; list readout and the closing result wait for it.
module positional_ordered_list_store_unit
    import polsu_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // operation, value, position
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // status, item_value, item_count, zero pad
    output logic                   m_axis_tlast
);

    localparam int OUT_USED_W = STATUS_W + VALUE_W + COUNT_W;
    localparam int ST_LO      = 0;
    localparam int CNT_LO     = STATUS_W + VALUE_W;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    logic [STATUS_W-1:0] res_status;
    logic [VALUE_W-1:0]  res_value;
    logic [COUNT_W-1:0]  res_count;

    polsu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    polsu_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_op     (s_axis_tdata[OP_W-1:0]),
        .req_value  (s_axis_tdata[OP_W +: VALUE_W]),
        .req_pos    (s_axis_tdata[OP_W + VALUE_W +: POS_W]),
        .cmd        (cmd),
        .stat       (stat),
        .res_ready  (m_axis_tready),
        .res_valid  (m_axis_tvalid),
        .res_status (res_status),
        .res_value  (res_value),
        .res_count  (res_count),
        .res_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, res_count, res_value, res_status};

    // One request at a time: ready drops right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while previous request still in progress");

    // A failed or empty result always closes its run
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[ST_LO +: STATUS_W] != STAT_OK) |-> m_axis_tlast)
    else $error("non-ok result without last marker");

    // Empty status only with an empty list
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[ST_LO +: STATUS_W] == STAT_EMPTY)
            |-> (m_axis_tdata[CNT_LO +: COUNT_W] == '0))
    else $error("empty status with nonzero count");

    // The walk never reaches an emit while the result register is occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_one || cmd.emit_list) |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwritten before it was taken");

endmodule

// ----- tb/testbench.sv -----
// Self-checking stream testbench for the positional ordered list store unit.
module testbench;
    import polsu_pkg::*;

    localparam int DEPTH = CAPACITY_DEF;
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 4 + 2 * DEPTH + 8;

    typedef struct {
        status_t           status;
        logic [VALUE_W-1:0] item_value;
        logic [COUNT_W-1:0] item_count;
        logic              last_item;
    } list_result_t;

    class list_tracker;
        logic [VALUE_W-1:0] shadow_entries [DEPTH];
        int                 shadow_count;
        list_result_t       due_results [$];
        int                 failures;
        int                 requests;
        int                 results;
        int                 list_entries;
        int                 status_seen [4];

        function new();
            shadow_count = 0;
            failures = 0;
            requests = 0;
            results = 0;
            list_entries = 0;
            foreach (status_seen[i])
                status_seen[i] = 0;
        endfunction

        function void push(status_t st, logic [VALUE_W-1:0] v, logic last);
            list_result_t r;
            r.status = st;
            r.item_value = v;
            r.item_count = shadow_count[COUNT_W-1:0];
            r.last_item = last;
            due_results.push_back(r);
            status_seen[st]++;
        endfunction

        // idx is zero-based, room already checked
        function void put_entry(int idx, logic [VALUE_W-1:0] v);
            for (int i = shadow_count; i > idx; i--)
                shadow_entries[i] = shadow_entries[i-1];
            shadow_entries[idx] = v;
            shadow_count++;
        endfunction

        function void take_entry(int idx);
            for (int i = idx; i + 1 < shadow_count; i++)
                shadow_entries[i] = shadow_entries[i+1];
            shadow_count--;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                                   logic [POS_W-1:0] pos);
            status_t st;
            int      p;
            st = STAT_OK;
            p = int'(pos);
            requests++;
            case (op)
                OP_INS_FRONT, OP_INS_BACK:
                    if (shadow_count >= DEPTH)
                        st = STAT_FULL;
                    else
                        put_entry(op == OP_INS_FRONT ? 0 : shadow_count, value);
                OP_INS_AT:
                    // position is checked before fullness
                    if (p < 1 || p > shadow_count + 1)
                        st = STAT_BADPOS;
                    else if (shadow_count >= DEPTH)
                        st = STAT_FULL;
                    else
                        put_entry(p - 1, value);
                OP_DEL_FRONT, OP_DEL_BACK:
                    if (shadow_count == 0)
                        st = STAT_EMPTY;
                    else
                        take_entry(op == OP_DEL_FRONT ? 0 : shadow_count - 1);
                OP_DEL_AT:
                    if (p < 1 || p > shadow_count)
                        st = STAT_BADPOS;
                    else
                        take_entry(p - 1);
                OP_LIST:
                begin
                    if (shadow_count == 0)
                        push(STAT_EMPTY, '0, 1'b1);
                    for (int i = 0; i < shadow_count; i++)
                        push(STAT_OK, shadow_entries[i], i + 1 == shadow_count);
                    list_entries += shadow_count;
                    return;
                end
                default: ;
            endcase
            push(st, '0, 1'b1);
        endfunction

        task report(string what, logic [VALUE_W-1:0] got, logic [VALUE_W-1:0] want);
            $display("tb: mismatch on result %0d: %s got %0h expected %0h",
                     results, what, got, want);
            failures++;
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] tdata, logic tlast);
            list_result_t want;
            results++;
            if (due_results.size() == 0)
            begin
                report("unexpected result, tdata", tdata[VALUE_W-1:0], '0);
                return;
            end
            want = due_results.pop_front();
            if (tdata[1:0] !== want.status)
                report("status", VALUE_W'(tdata[1:0]), VALUE_W'(want.status));
            if (tdata[33:2] !== want.item_value)
                report("item_value", tdata[33:2], want.item_value);
            if (tdata[38:34] !== want.item_count)
                report("item_count", VALUE_W'(tdata[38:34]), VALUE_W'(want.item_count));
            if (tlast !== want.last_item)
                report("last_item", VALUE_W'(tlast), VALUE_W'(want.last_item));
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    list_tracker sb = new();
    int          quiet_cycles = 0;
    int          sink_cycle = 0;
    int          sink_mode = 0;
    int          burst_left = 0;

    positional_ordered_list_store_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver: drives tready in one of four stall patterns, redrawn at random at regular intervals
    always @(negedge clk)
    begin
        sink_cycle++;
        if (sink_cycle % 97 == 0)
            sink_mode = $urandom_range(0, 3);
        case (sink_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= (sink_cycle % 4 == 0);
            default: m_axis_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    always @(posedge clk)
    begin
        if (rst_n && !(s_axis_tvalid && s_axis_tready) && !(m_axis_tvalid && m_axis_tready))
            quiet_cycles++;
        else
            quiet_cycles = 0;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: watchdog expired after %0d idle cycles", quiet_cycles);
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                                logic [POS_W-1:0] pos);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {pos, value, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(op, value, pos);
    endtask

    task automatic idle_sender(int cycles);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    // Hold off new requests until every outstanding result is back
    task automatic wait_drained();
        idle_sender(1);
        while (sb.due_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random(int ins_pct, int del_pct, int max_burst);
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   pos;
        int                 r;
        int                 cnt;
        if (burst_left == 0)
        begin
            idle_sender($urandom_range(1, 8));
            burst_left = $urandom_range(1, max_burst);
        end
        burst_left--;
        cnt = sb.shadow_count;
        r = $urandom_range(0, 99);
        if (r < ins_pct)
            op = OP_INS_FRONT + OP_W'($urandom_range(0, 2));
        else if (r < ins_pct + del_pct)
            op = OP_DEL_FRONT + OP_W'($urandom_range(0, 2));
        else if (r < 98)
            op = OP_LIST;
        else
            op = OP_UNUSED;
        r = $urandom_range(0, 9);
        value = (r == 0) ? '0 : (r == 1) ? '1 : $urandom;
        // mostly legal positions, some anywhere in the field
        pos = POS_W'($urandom_range(0, 31));
        if ($urandom_range(0, 99) < 85)
        begin
            if (op == OP_INS_AT)
                pos = POS_W'($urandom_range(1, cnt + 1));
            else if (op == OP_DEL_AT && cnt > 0)
                pos = POS_W'($urandom_range(1, cnt));
        end
        send_request(op, value, pos);
    endtask

    initial
    begin
        repeat (3)
            @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty-list errors, edge positions, field extremes
        send_request(OP_LIST, '0, '0);
        send_request(OP_DEL_FRONT, '0, '0);
        send_request(OP_DEL_BACK, '1, '1);
        send_request(OP_DEL_AT, '0, 5'd0);
        send_request(OP_DEL_AT, '0, 5'd1);
        send_request(OP_INS_AT, 32'h1111_1111, 5'd0);
        send_request(OP_INS_AT, 32'h2222_2222, 5'd2);
        send_request(OP_INS_FRONT, 32'h0000_0000, '0);
        send_request(OP_INS_BACK, 32'hFFFF_FFFF, '0);
        send_request(OP_INS_AT, 32'hA5A5_A5A5, 5'd2);
        send_request(OP_INS_AT, 32'h5A5A_5A5A, 5'd4);
        send_request(OP_INS_AT, 32'h3333_3333, 5'd31);
        send_request(OP_INS_AT, 32'h1234_5678, 5'd1);
        send_request(OP_LIST, '0, '0);
        send_request(OP_UNUSED, '0, '0);
        send_request(OP_DEL_AT, '0, 5'd31);
        send_request(OP_DEL_AT, '0, 5'd5);
        send_request(OP_DEL_AT, '0, 5'd2);
        send_request(OP_DEL_FRONT, '0, '0);
        send_request(OP_DEL_BACK, '0, '0);
        send_request(OP_LIST, '0, '0);
        send_request(OP_DEL_AT, '0, 5'd1);
        send_request(OP_UNUSED, '1, '1);
        wait_drained();

        // random phases: grow to full, shrink to empty, churn, grow in long bursts
        repeat (65)
            send_random(70, 18, 12);
        wait_drained();
        repeat (65)
            send_random(18, 70, 12);
        wait_drained();
        repeat (65)
            send_random(44, 44, 12);
        wait_drained();
        repeat (65)
            send_random(70, 18, 40);
        wait_drained();

        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (sb.due_results.size() != 0)
            sb.report("results still outstanding", sb.due_results.size(), '0);
        $display("tb: %0d requests, %0d results checked, %0d list entries read out",
                 sb.requests, sb.results, sb.list_entries);
        $display("tb: status ok %0d, bad position %0d, full %0d, empty %0d",
                 sb.status_seen[STAT_OK], sb.status_seen[STAT_BADPOS],
                 sb.status_seen[STAT_FULL], sb.status_seen[STAT_EMPTY]);
        if (sb.failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/polsu_pkg.sv
rtl/polsu_ctrl.sv
rtl/polsu_dp.sv
rtl/positional_ordered_list_store_unit.sv
tb/testbench.sv
